/* rtl/core/block_sparse_matvec_4x4_fixed_defines.svh */
// Assertion macros for the checker file of the block-sparse matvec core.
// No dependencies; include by bare file name inside a module body.
`ifndef BLOCK_SPARSE_MATVEC_4X4_FIXED_DEFINES_SVH
`define BLOCK_SPARSE_MATVEC_4X4_FIXED_DEFINES_SVH

// Same-cycle implication, sampled on clk, dropped while rst_n is low.
`define BSMV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, dropped while rst_n is low.
`define BSMV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Delayed implication, sampled on clk, dropped while rst_n is low.
`define BSMV_ASSERT_AFTER3(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##3 (cons)) \
    else $error(msg);

`endif

/* rtl/core/bsmv_pkg.sv */
// Shared types and constants of the block-sparse matvec core.
// No dependencies; imported by the controller, datapath and top level.
package bsmv_pkg;

  localparam int IDX_W      = 10;
  localparam int VAL_W      = 32;
  localparam int ELEM_W     = 16;
  localparam int LANES      = 4;
  localparam int LANE_W     = 2;
  localparam int BLK_W      = ELEM_W * LANES;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int SHIFT_W    = 5;

  localparam logic signed [VAL_W-1:0] SAT_MAX = 32'sd32767;
  localparam logic signed [VAL_W-1:0] SAT_MIN = -32'sd32768;

  typedef enum logic [1:0] {
    ACT_LOAD   = 2'd0,
    ACT_BIAS   = 2'd1,
    ACT_WEIGHT = 2'd2,
    ACT_FINISH = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RELU   = 2'd0,
    CFG_SHIFT  = 2'd1,
    CFG_NARROW = 2'd2
  } cfg_reg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_ACC,
    ST_RND,
    ST_FIN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_vec;
    logic load_bias;
    logic take_row;
    logic do_mul;
    logic do_sum;
    logic do_acc;
    logic do_rnd;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

/* rtl/core/bsmv_ctrl.sv */
// Sequencing state machine of the block-sparse matvec core.
// Depends on bsmv_pkg; drives the datapath commands and the input stall.
module bsmv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [1:0]        in_action,
  output logic              in_stall,
  output bsmv_pkg::cmd_t    cmd,
  input  bsmv_pkg::stat_t   stat
);
  import bsmv_pkg::*;

  state_t state_r;
  state_t state_nxt;
  logic   accept;

  assign accept = in_valid && (state_r == ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_action == ACT_WEIGHT) begin
            state_nxt = ST_MUL;
          end else if (in_action == ACT_FINISH) begin
            state_nxt = ST_RND;
          end
        end
      end
      ST_MUL:  state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_IDLE;
      ST_RND:  state_nxt = ST_FIN;
      ST_FIN: begin
        if (stat.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_vec  = accept && (in_action == ACT_LOAD);
        cmd.load_bias = accept && (in_action == ACT_BIAS);
        cmd.take_row  = accept && (in_action == ACT_WEIGHT);
      end
      ST_MUL:  cmd.do_mul = 1'b1;
      ST_SUM:  cmd.do_sum = 1'b1;
      ST_ACC:  cmd.do_acc = 1'b1;
      ST_RND:  cmd.do_rnd = 1'b1;
      ST_FIN:  cmd.load_out = stat.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

/* rtl/core/bsmv_datapath.sv */
// Vector store, multiply-accumulate lanes, output stage and config registers.
// Depends on bsmv_pkg; steered by bsmv_ctrl through cmd_t.
module bsmv_datapath #(
  parameter int VECTOR_BLOCKS = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  bsmv_pkg::cmd_t                         cmd,
  output bsmv_pkg::stat_t                        stat,
  input  logic [bsmv_pkg::IDX_W-1:0]             in_block_index,
  input  logic [bsmv_pkg::LANE_W-1:0]            in_lane,
  input  logic signed [bsmv_pkg::VAL_W-1:0]      in_value0,
  input  logic signed [bsmv_pkg::VAL_W-1:0]      in_value1,
  input  logic signed [bsmv_pkg::VAL_W-1:0]      in_value2,
  input  logic signed [bsmv_pkg::VAL_W-1:0]      in_value3,
  input  logic                                   cfg_we,
  input  logic [bsmv_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bsmv_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [bsmv_pkg::VAL_W-1:0]      out_result0,
  output logic signed [bsmv_pkg::VAL_W-1:0]      out_result1,
  output logic signed [bsmv_pkg::VAL_W-1:0]      out_result2,
  output logic signed [bsmv_pkg::VAL_W-1:0]      out_result3
);
  import bsmv_pkg::*;

  localparam int AW = (VECTOR_BLOCKS > 1) ? $clog2(VECTOR_BLOCKS) : 1;

  logic [BLK_W-1:0]        vec_mem [VECTOR_BLOCKS];
  logic [AW+IDX_W-1:0]     addr_ext;
  logic [AW-1:0]           addr;
  logic                    in_range;

  logic signed [VAL_W-1:0] in_vals [LANES];
  logic [BLK_W-1:0]        vec_r;
  logic                    vec_ok_r;
  logic [ELEM_W-1:0]       w_r    [LANES];
  logic [LANE_W-1:0]       lane_r;
  logic signed [VAL_W-1:0] prod_nxt [LANES];
  logic signed [VAL_W-1:0] prod_r [LANES];
  logic [VAL_W-1:0]        dot_r;
  logic [VAL_W-1:0]        acc_r  [LANES];
  logic [VAL_W-1:0]        rnd_r  [LANES];
  logic [VAL_W-1:0]        round_const;
  logic signed [VAL_W-1:0] fin_nxt [LANES];
  logic signed [VAL_W-1:0] out_r  [LANES];
  logic                    out_valid_r;

  logic                    relu_r;
  logic [SHIFT_W-1:0]      shift_r;
  logic                    narrow_r;

  assign in_vals[0] = in_value0;
  assign in_vals[1] = in_value1;
  assign in_vals[2] = in_value2;
  assign in_vals[3] = in_value3;

  assign addr_ext = {{AW{1'b0}}, in_block_index};
  assign addr     = addr_ext[AW-1:0];
  assign in_range = ({{(32-IDX_W){1'b0}}, in_block_index} < 32'(VECTOR_BLOCKS));

  // Config registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relu_r   <= 1'b0;
      shift_r  <= '0;
      narrow_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RELU:   relu_r   <= cfg_data[0];
        CFG_SHIFT:  shift_r  <= cfg_data[SHIFT_W-1:0];
        CFG_NARROW: narrow_r <= cfg_data[0];
        default:    ;
      endcase
    end
  end

  // Vector store: one write or one registered read per accepted word.
  always_ff @(posedge clk) begin
    if (cmd.load_vec && in_range) begin
      vec_mem[addr] <= {in_vals[3][ELEM_W-1:0], in_vals[2][ELEM_W-1:0],
                        in_vals[1][ELEM_W-1:0], in_vals[0][ELEM_W-1:0]};
    end
    if (cmd.take_row) begin
      vec_r <= vec_mem[addr];
    end
  end

  // Latch the weight row and its lane.
  always_ff @(posedge clk) begin
    if (cmd.take_row) begin
      vec_ok_r <= in_range;
      lane_r   <= in_lane;
      for (int i = 0; i < LANES; i++) begin
        w_r[i] <= in_vals[i][ELEM_W-1:0];
      end
    end
  end

  // Four 16x16 products; an out-of-range block reads as zero.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      if (vec_ok_r) begin
        prod_nxt[i] = $signed(w_r[i]) * $signed(vec_r[i*ELEM_W +: ELEM_W]);
      end else begin
        prod_nxt[i] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_mul) begin
      prod_r <= prod_nxt;
    end
    if (cmd.do_sum) begin
      dot_r <= VAL_W'(prod_r[0] + prod_r[1] + prod_r[2] + prod_r[3]);
    end
  end

  // Accumulators wrap modulo 2^32.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        acc_r[i] <= '0;
      end
    end else if (cmd.load_bias) begin
      for (int i = 0; i < LANES; i++) begin
        acc_r[i] <= in_vals[i];
      end
    end else if (cmd.do_acc) begin
      acc_r[lane_r] <= acc_r[lane_r] + dot_r;
    end
  end

  // Round half up ahead of the shift.
  assign round_const = (shift_r == '0) ? '0 : (VAL_W'(1) << (shift_r - SHIFT_W'(1)));

  always_ff @(posedge clk) begin
    if (cmd.do_rnd) begin
      for (int i = 0; i < LANES; i++) begin
        rnd_r[i] <= acc_r[i] + round_const;
      end
    end
  end

  // Shift, ReLU, optional int16 saturation.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      fin_nxt[i] = $signed(rnd_r[i]) >>> shift_r;
      if (relu_r && fin_nxt[i][VAL_W-1]) begin
        fin_nxt[i] = '0;
      end
      if (narrow_r) begin
        if (fin_nxt[i] < SAT_MIN) begin
          fin_nxt[i] = SAT_MIN;
        end else if (fin_nxt[i] > SAT_MAX) begin
          fin_nxt[i] = SAT_MAX;
        end
      end
    end
  end

  // Output register: free when empty or being taken this cycle.
  assign stat.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_result0 = out_r[0];
  assign out_result1 = out_r[1];
  assign out_result2 = out_r[2];
  assign out_result3 = out_r[3];

endmodule

/* rtl/core/block_sparse_matvec_4x4_fixed.sv */
// Top level of the block-sparse 4x4 int16 matrix-vector core.
// Depends on bsmv_pkg, bsmv_ctrl and bsmv_datapath.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command word: in_action
//   picks load vector block, begin row with bias, weight row or finish row.
//   Load the vector blocks first, then per block row: one bias word, any
//   number of weight-row words, one finish word.
//   The result channel (out_valid / out_stall) carries one word of four int32
//   rows for each finish word. The config port (cfg_valid / cfg_ready) is
//   always ready; write it only while the core is idle.
// Steps:
//   Load and bias words complete when they are accepted. A weight row passes
//   a registered vector-store read, a multiply stage, a four-term add and the
//   accumulator update, all on one shared multiply-add path; new words stall.
//   A finish word passes accept, round add and shift/ReLU/saturate into the
//   output register; out_valid rises once that register is loaded.
// Stall and reset:
//   A stalled result holds in the output register while new words are taken;
//   a second finish waits in its last step until that register frees up.
//   Reset clears control, accumulators and config; the vector store is not
//   cleared, so read only blocks that were loaded.
module block_sparse_matvec_4x4_fixed #(
  parameter int VECTOR_BLOCKS = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic [1:0]                             in_action,
  input  logic [bsmv_pkg::IDX_W-1:0]             in_block_index,
  input  logic [bsmv_pkg::LANE_W-1:0]            in_lane,
  input  logic signed [bsmv_pkg::VAL_W-1:0]      in_value0,
  input  logic signed [bsmv_pkg::VAL_W-1:0]      in_value1,
  input  logic signed [bsmv_pkg::VAL_W-1:0]      in_value2,
  input  logic signed [bsmv_pkg::VAL_W-1:0]      in_value3,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [bsmv_pkg::VAL_W-1:0]      out_result0,
  output logic signed [bsmv_pkg::VAL_W-1:0]      out_result1,
  output logic signed [bsmv_pkg::VAL_W-1:0]      out_result2,
  output logic signed [bsmv_pkg::VAL_W-1:0]      out_result3,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [bsmv_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [bsmv_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import bsmv_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Config registers take a write every cycle.
  assign cfg_ready = 1'b1;

  bsmv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  bsmv_datapath #(
    .VECTOR_BLOCKS (VECTOR_BLOCKS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_block_index (in_block_index),
    .in_lane        (in_lane),
    .in_value0      (in_value0),
    .in_value1      (in_value1),
    .in_value2      (in_value2),
    .in_value3      (in_value3),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result0    (out_result0),
    .out_result1    (out_result1),
    .out_result2    (out_result2),
    .out_result3    (out_result3)
  );

endmodule

/* rtl/core/bsmv_checker.sv */
// Port-level checks of the block-sparse matvec core, bound to its top level.
// Depends on bsmv_pkg and block_sparse_matvec_4x4_fixed_defines.svh.
module bsmv_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_valid,
  input logic                               in_stall,
  input logic [1:0]                         in_action,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [bsmv_pkg::VAL_W-1:0]  out_result0,
  input logic signed [bsmv_pkg::VAL_W-1:0]  out_result1,
  input logic signed [bsmv_pkg::VAL_W-1:0]  out_result2,
  input logic signed [bsmv_pkg::VAL_W-1:0]  out_result3
);
  import bsmv_pkg::*;
  `include "block_sparse_matvec_4x4_fixed_defines.svh"

  logic in_acc;
  assign in_acc = in_valid && !in_stall;

  // A stalled result word holds.
  `BSMV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_result0) && $stable(out_result1) && $stable(out_result2) && $stable(out_result3), "stalled result changed")

  // An accepted weight row occupies the multiply-add path and stalls the input.
  `BSMV_ASSERT_NEXT(a_weight_busy, in_acc && (in_action == ACT_WEIGHT), in_stall, "weight row not stalled")

  // Load and bias words leave the input unstalled in the next cycle.
  `BSMV_ASSERT_NEXT(a_single_cycle, in_acc && ((in_action == ACT_LOAD) || (in_action == ACT_BIAS)), !in_stall, "load or bias word stalled")

  // With the output register empty, a finish word shows its result after the round add and the output load.
  `BSMV_ASSERT_AFTER3(a_finish_latency, in_acc && (in_action == ACT_FINISH) && !out_valid, out_valid, "finish result late")

endmodule

bind block_sparse_matvec_4x4_fixed bsmv_checker u_bsmv_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .in_action   (in_action),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_result0 (out_result0),
  .out_result1 (out_result1),
  .out_result2 (out_result2),
  .out_result3 (out_result3)
);
